@@ sv/mce_pkg.sv @@
`timescale 1ns / 1ps

package mce_pkg;

  localparam int MaxResults = 3;
  localparam int BufDepth   = 4;

  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChT = 8'h54;

  typedef enum logic [1:0] {
    CTX_CPG  = 2'd0,
    CTX_CHG  = 2'd1,
    CTX_CHH  = 2'd2,
    CTX_NONE = 2'd3
  } ctx_e;

  typedef enum logic [3:0] {
    NUC_A = 4'd0,
    NUC_C = 4'd1,
    NUC_G = 4'd2,
    NUC_T = 4'd3,
    NUC_N = 4'd4
  } nuc_e;

  typedef struct packed {
    logic [7:0] base;
    logic       chrom_end;
  } in_t;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0]                 num;
    logic [MaxResults-1:0][5:0] code;
  } grp_t;

  function automatic nuc_e nuc_code(input logic [7:0] b);
    nuc_e n;
    case (b)
      ChA:     n = NUC_A;
      ChC:     n = NUC_C;
      ChG:     n = NUC_G;
      ChT:     n = NUC_T;
      default: n = NUC_N;
    endcase
    return n;
  endfunction

  // n1/n2 are one and two bases ahead, p1/p2 one and two behind
  function automatic ctx_e ctx_of(input logic [7:0] cur, input logic [7:0] n1,
                                  input logic [7:0] n2, input logic [7:0] p1,
                                  input logic [7:0] p2, input logic vp1,
                                  input logic vp2);
    ctx_e c;
    if (cur == ChC) begin
      if (n1 == ChG) c = CTX_CPG;
      else if (n2 == ChG) c = CTX_CHG;
      else c = CTX_CHH;
    end else if (cur == ChG) begin
      if (vp1 && p1 == ChC) c = CTX_CPG;
      else if (vp2 && p2 == ChC) c = CTX_CHG;
      else c = CTX_CHH;
    end else begin
      c = CTX_NONE;
    end
    return c;
  endfunction

endpackage

@@ sv/mce_window.sv @@
`timescale 1ns / 1ps

module mce_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  mce_pkg::in_t  beat_i,
  output mce_pkg::grp_t grp_o
);

  logic [3:0][7:0] win_q, win_d;
  logic [1:0]      pend_q, pend_d;
  logic [1:0]      hist_q, hist_d;

  logic [1:0]      p;
  logic [1:0]      h;
  logic [2:0]      len;
  logic [2:0]      lo;
  logic [7:0]      e [7];
  logic [2:0][5:0] cd;
  logic [2:0]      first;

  always_comb begin
    p   = (pend_q == 2'd3) ? 2'd2 : pend_q;
    h   = (hist_q == 2'd3) ? 2'd2 : hist_q;
    len = {1'b0, h} + {1'b0, p};
    lo  = 3'd4 - len;
    for (int k = 0; k < 4; k++) begin
      e[k] = win_q[k];
    end
    e[4] = beat_i.base;
    e[5] = '0;
    e[6] = '0;
    for (int j = 2; j < 5; j++) begin
      cd[j-2] = {mce_pkg::ctx_of(e[j], e[j+1], e[j+2], e[j-1], e[j-2],
                                 (3'(j - 1) >= lo), (3'(j - 2) >= lo)),
                 mce_pkg::nuc_code(e[j])};
    end
  end

  // results for this beat, oldest first
  always_comb begin
    grp_o.num  = 2'd0;
    grp_o.code = '0;
    if (beat_i.chrom_end) begin
      grp_o.num = p + 2'd1;
      case (p)
        2'd0: grp_o.code[0] = cd[2];
        2'd1: begin
          grp_o.code[0] = cd[1];
          grp_o.code[1] = cd[2];
        end
        default: grp_o.code = cd;
      endcase
    end else if (p == 2'd2) begin
      grp_o.num     = 2'd1;
      grp_o.code[0] = cd[0];
    end
  end

  always_comb begin
    win_d  = win_q;
    pend_d = pend_q;
    hist_d = hist_q;
    first  = {1'b0, h} + {2'b0, (p == 2'd2)};
    if (accept_i) begin
      if (beat_i.chrom_end) begin
        win_d  = '0;
        pend_d = 2'd0;
        hist_d = 2'd0;
      end else begin
        win_d  = {beat_i.base, win_q[3], win_q[2], win_q[1]};
        pend_d = (p == 2'd2) ? 2'd2 : p + 2'd1;
        hist_d = (first > 3'd2) ? 2'd2 : first[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pend_q <= 2'd0;
      hist_q <= 2'd0;
    end else begin
      win_q  <= win_d;
      pend_q <= pend_d;
      hist_q <= hist_d;
    end
  end

endmodule

@@ sv/mce_out_buf.sv @@
`timescale 1ns / 1ps

module mce_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mce_pkg::grp_t grp_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mce_pkg::out_t out_data_o
);

  localparam int CntW = $clog2(mce_pkg::BufDepth + 1);

  logic [5:0]      code_q [mce_pkg::BufDepth];
  logic [5:0]      code_d [mce_pkg::BufDepth];
  logic            last_q [mce_pkg::BufDepth];
  logic            last_d [mce_pkg::BufDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [CntW-1:0] base;
  logic [CntW-1:0] num;
  logic [CntW-1:0] rel;

  assign out_valid_o     = (cnt_q != '0);
  assign out_data_o.code = code_q[0];
  assign out_data_o.last = last_q[0];
  assign room_o          = (cnt_q <= CntW'(1));
  assign pop             = out_valid_o && out_ready_i;

  always_comb begin
    base  = cnt_q - CntW'(pop);
    num   = load_i ? CntW'(grp_i.num) : '0;
    cnt_d = base + num;
    rel   = '0;
    for (int i = 0; i < mce_pkg::BufDepth; i++) begin
      if (pop && i < mce_pkg::BufDepth - 1) begin
        code_d[i] = code_q[i+1];
        last_d[i] = last_q[i+1];
      end else begin
        code_d[i] = code_q[i];
        last_d[i] = last_q[i];
      end
      rel = CntW'(i) - base;
      if (CntW'(i) >= base && CntW'(i) < base + num) begin
        code_d[i] = grp_i.code[rel[1:0]];
        last_d[i] = (rel == num - CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < mce_pkg::BufDepth; i++) begin
      code_q[i] <= code_d[i];
      last_q[i] <= last_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/methylation_context_encoder_core.sv @@
`timescale 1ns / 1ps

// Methylation context encoder: one ASCII reference base per input beat, one
// 6-bit result code per base (context in code[5:4], nucleotide in
// code[3:0]), two bases behind the input, with chrom_end flushing the
// pending bases. Input and result are decoupled by a four-entry result
// buffer. While the result port is not stalled, a beat that yields at most
// one result is taken every cycle, so a steady base stream runs at one base
// per cycle. A chromosome-end beat yields up to three results; the single
// result port drains them one per cycle unless stalled, and the input is
// held off while more than one result waits.
module methylation_context_encoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mce_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mce_pkg::out_t out_data_o
);

  logic          accept;
  mce_pkg::grp_t grp;

  assign accept = in_valid_i && in_ready_o;

  mce_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_data_i),
    .grp_o    (grp)
  );

  mce_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .grp_i       (grp),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/mce_checker.sv @@
`timescale 1ns / 1ps

module mce_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input mce_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mce_pkg::out_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // chromosome end always answers at least one base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.chrom_end |=> out_valid_o)
    else $error("no result after chromosome end");

  // input only backs up behind waiting results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // non-C/G bases carry no context, C/G always do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.code[5:4] == mce_pkg::CTX_NONE) ==
                     (out_data_o.code[3:0] != mce_pkg::NUC_C &&
                      out_data_o.code[3:0] != mce_pkg::NUC_G)))
    else $error("context does not match nucleotide");

endmodule

bind methylation_context_encoder_core mce_checker u_mce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
